>>> sv/dmnt_pkg.sv
// Shared types and constants for the direct-mapped name table.
// Holds the word formats of both channels, operation and status codes, and the FSM state type.
// No dependencies.
package dmnt_pkg;

  localparam int KEY_CHAR_W = 7;
  localparam int CHAR_MAX   = 127;
  localparam int AGE_W      = 16;
  localparam int OP_W       = 2;
  localparam int STATUS_W   = 2;
  localparam int SLOT_OUT_W = 7;

  // Operation codes, sampled with the final character of a name.
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_OCCUPIED  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd2;

  // One input word: a single character of a name plus the operation fields.
  typedef struct packed {
    logic [OP_W-1:0]       operation;
    logic [KEY_CHAR_W-1:0] key_char;
    logic                  key_last;
    logic [AGE_W-1:0]      entry_age;
  } in_word_t;

  // One result word, given once per completed name.
  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [AGE_W-1:0]      found_age;
    logic [SLOT_OUT_W-1:0] slot_index;
  } out_word_t;

  // Sequencer states of the top level.
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_REC_RD,
    S_REC_CHK,
    S_COPY,
    S_CMP,
    S_DONE
  } state_t;

endpackage

>>> sv/dmnt_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for every storage array of the name table. No dependencies.
module dmnt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; registered, so data appears in the cycle after the address when rd_en is high.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> sv/dmnt_hash.sv
// Slot hash step of the name table: next = ((h + c) * c) mod TABLE_SLOTS.
// Three-stage pipeline using a reciprocal multiply with one correction. Depends on dmnt_pkg.
module dmnt_hash #(
  parameter int TABLE_SLOTS = 100,
  localparam int SLOT_W = $clog2(TABLE_SLOTS)
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [SLOT_W-1:0]               hash_in,
  input  logic [dmnt_pkg::KEY_CHAR_W-1:0] char_in,
  output logic                            done,
  output logic [SLOT_W-1:0]               hash_out
);

  import dmnt_pkg::*;

  localparam int SUM_MAX = TABLE_SLOTS - 1 + CHAR_MAX;
  localparam int SUM_W   = $clog2(SUM_MAX + 1);
  localparam int P_W     = $clog2(SUM_MAX * CHAR_MAX + 1);
  localparam int RECIP   = (1 << P_W) / TABLE_SLOTS;

  logic [SUM_W-1:0]   sum;
  logic [P_W-1:0]     prod_nxt;
  logic [P_W-1:0]     prod_r;
  logic [P_W-1:0]     prod2_r;
  logic [2*P_W-1:0]   full;
  logic [P_W-1:0]     quo_r;
  logic [P_W-1:0]     rem;
  logic               v1_r;
  logic               v2_r;

  // Stage one: add the character and multiply by it.
  assign sum      = SUM_W'(hash_in) + SUM_W'(char_in);
  assign prod_nxt = P_W'(sum) * P_W'(char_in);

  // Stage two: quotient estimate by the scaled reciprocal of the slot count.
  // The estimate is low by at most one, since the product stays below 2**P_W.
  assign full = (2*P_W)'(prod_r) * (2*P_W)'(RECIP);

  // Stage three: remainder with a single corrective subtract.
  assign rem      = prod2_r - quo_r * P_W'(TABLE_SLOTS);
  assign hash_out = (rem >= P_W'(TABLE_SLOTS)) ? SLOT_W'(rem - P_W'(TABLE_SLOTS))
                                               : SLOT_W'(rem);
  assign done     = v2_r;

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (start) begin
      prod_r <= prod_nxt;
    end
    prod2_r <= prod_r;
    quo_r   <= full[2*P_W-1:P_W];
  end

  // Stage valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= start;
      v2_r <= v1_r;
    end
  end

endmodule

>>> sv/direct_mapped_name_table.sv
// Direct-mapped name table. Names arrive one character per input word; each character
// moves a running slot hash and is kept in a key buffer, and the word marked last carries
// out insert, delete or lookup at the hashed slot, giving one result word (any other
// operation code answers not found). Characters beyond NAME_MAX_LEN are dropped. Each
// character that is hashed must pass the three-stage hash pipeline before the block takes
// the next word, since the next character uses its result; a dropped character skips it.
// The final character adds a record read and check, then, for an insert into a free slot or
// for a delete or lookup whose occupied slot holds a name of the same length, a walk
// through the name memory (a compare stops at the first differing character), and a
// hand-over of the result to the output register, which waits while that register still
// holds a word that has not been taken. After reset the block marks every slot record
// unused before it takes its first word.
// Depends on dmnt_pkg, dmnt_ram and dmnt_hash.
module direct_mapped_name_table #(
  parameter int TABLE_SLOTS  = 100,
  parameter int NAME_MAX_LEN = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  dmnt_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output dmnt_pkg::out_word_t out_word
);

  import dmnt_pkg::*;

  localparam int SLOT_W   = $clog2(TABLE_SLOTS);
  localparam int LEN_W    = $clog2(NAME_MAX_LEN + 1);
  localparam int KEY_AW   = (NAME_MAX_LEN > 1) ? $clog2(NAME_MAX_LEN) : 1;
  localparam int NB_DEPTH = TABLE_SLOTS * NAME_MAX_LEN;
  localparam int NB_AW    = $clog2(NB_DEPTH);
  localparam int REC_W    = 1 + AGE_W + LEN_W;

  // Control and payload registers.
  state_t            state_r, state_nxt;
  logic [SLOT_W-1:0] clr_idx_r, clr_idx_nxt;
  logic [LEN_W-1:0]  key_count_r, key_count_nxt;
  logic [SLOT_W-1:0] hash_r, hash_nxt;
  in_word_t          word_r, word_nxt;
  logic [LEN_W-1:0]  walk_idx_r, walk_idx_nxt;
  logic [LEN_W-1:0]  wr_idx_r, wr_idx_nxt;
  logic              pend_r, pend_nxt;
  logic [NB_AW-1:0]  name_base_r, name_base_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [AGE_W-1:0]  found_r, found_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_word_t         out_word_r, out_word_nxt;

  // Memory ports.
  logic              rec_wr_en, rec_rd_en;
  logic [SLOT_W-1:0] rec_wr_addr;
  logic [REC_W-1:0]  rec_wr_data, rec_rd_data;
  logic              key_wr_en, key_rd_en;
  logic [KEY_AW-1:0] key_wr_addr, key_rd_addr;
  logic [KEY_CHAR_W-1:0] key_rd_data;
  logic              nb_wr_en, nb_rd_en;
  logic [NB_AW-1:0]  nb_wr_addr, nb_rd_addr;
  logic [KEY_CHAR_W-1:0] nb_rd_data;

  // Hash unit.
  logic              hash_start, hash_done;
  logic [SLOT_W-1:0] hash_out;

  // Decoded record and misc.
  logic              rec_used;
  logic [AGE_W-1:0]  rec_age;
  logic [LEN_W-1:0]  rec_len;
  logic              in_fire;
  logic              walk_end;
  logic [SLOT_W+SLOT_OUT_W-1:0] slot_ext;

  assign in_stall  = (state_r != S_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  assign rec_used = rec_rd_data[REC_W-1];
  assign rec_age  = rec_rd_data[LEN_W +: AGE_W];
  assign rec_len  = rec_rd_data[LEN_W-1:0];
  assign walk_end = (walk_idx_r == key_count_r);
  assign slot_ext = {{SLOT_OUT_W{1'b0}}, hash_r};

  // Slot records: used flag, age and name length.
  dmnt_ram #(.WIDTH(REC_W), .DEPTH(TABLE_SLOTS)) u_rec_ram (
    .clk     (clk),
    .wr_en   (rec_wr_en),
    .wr_addr (rec_wr_addr),
    .wr_data (rec_wr_data),
    .rd_en   (rec_rd_en),
    .rd_addr (hash_r),
    .rd_data (rec_rd_data)
  );

  // Characters of the name being collected.
  dmnt_ram #(.WIDTH(KEY_CHAR_W), .DEPTH(NAME_MAX_LEN)) u_key_ram (
    .clk     (clk),
    .wr_en   (key_wr_en),
    .wr_addr (key_wr_addr),
    .wr_data (in_word.key_char),
    .rd_en   (key_rd_en),
    .rd_addr (key_rd_addr),
    .rd_data (key_rd_data)
  );

  // Stored names, NAME_MAX_LEN characters per slot.
  dmnt_ram #(.WIDTH(KEY_CHAR_W), .DEPTH(NB_DEPTH)) u_name_ram (
    .clk     (clk),
    .wr_en   (nb_wr_en),
    .wr_addr (nb_wr_addr),
    .wr_data (key_rd_data),
    .rd_en   (nb_rd_en),
    .rd_addr (nb_rd_addr),
    .rd_data (nb_rd_data)
  );

  dmnt_hash #(.TABLE_SLOTS(TABLE_SLOTS)) u_hash (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (hash_start),
    .hash_in  (hash_r),
    .char_in  (in_word.key_char),
    .done     (hash_done),
    .hash_out (hash_out)
  );

  // Next state, memory control and result capture.
  always_comb begin
    state_nxt     = state_r;
    clr_idx_nxt   = clr_idx_r;
    key_count_nxt = key_count_r;
    hash_nxt      = hash_r;
    word_nxt      = word_r;
    walk_idx_nxt  = walk_idx_r;
    wr_idx_nxt    = wr_idx_r;
    pend_nxt      = pend_r;
    name_base_nxt = name_base_r;
    status_nxt    = status_r;
    found_nxt     = found_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_word_nxt  = out_word_r;

    rec_wr_en   = 1'b0;
    rec_wr_addr = hash_r;
    rec_wr_data = '0;
    rec_rd_en   = 1'b0;
    key_wr_en   = 1'b0;
    key_wr_addr = key_count_r[KEY_AW-1:0];
    key_rd_en   = 1'b0;
    key_rd_addr = walk_idx_r[KEY_AW-1:0];
    nb_wr_en    = 1'b0;
    nb_wr_addr  = name_base_r + NB_AW'(wr_idx_r);
    nb_rd_en    = 1'b0;
    nb_rd_addr  = name_base_r + NB_AW'(walk_idx_r);
    hash_start  = 1'b0;

    case (state_r)
      // Mark every slot unused after reset.
      S_CLEAR: begin
        rec_wr_en   = 1'b1;
        rec_wr_addr = clr_idx_r;
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == SLOT_W'(TABLE_SLOTS - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      // Take one character; hash and keep it unless the name is already full.
      S_IDLE: begin
        if (in_fire) begin
          word_nxt = in_word;
          if (key_count_r < LEN_W'(NAME_MAX_LEN)) begin
            key_wr_en     = 1'b1;
            hash_start    = 1'b1;
            key_count_nxt = key_count_r + 1'b1;
            state_nxt     = S_HASH;
          end else if (in_word.key_last) begin
            state_nxt = S_REC_RD;
          end
        end
      end

      // Wait for the hash pipeline.
      S_HASH: begin
        if (hash_done) begin
          hash_nxt  = hash_out;
          state_nxt = word_r.key_last ? S_REC_RD : S_IDLE;
        end
      end

      // Read the slot record and form the name base address.
      S_REC_RD: begin
        rec_rd_en     = 1'b1;
        name_base_nxt = NB_AW'(hash_r) * NB_AW'(NAME_MAX_LEN);
        state_nxt     = S_REC_CHK;
      end

      // Decide the operation from the slot record.
      S_REC_CHK: begin
        walk_idx_nxt = '0;
        pend_nxt     = 1'b0;
        found_nxt    = '0;
        status_nxt   = STAT_NOT_FOUND;
        state_nxt    = S_DONE;
        case (word_r.operation)
          OP_INSERT: begin
            if (rec_used) begin
              status_nxt = STAT_OCCUPIED;
            end else begin
              rec_wr_en   = 1'b1;
              rec_wr_data = {1'b1, word_r.entry_age, key_count_r};
              status_nxt  = STAT_OK;
              state_nxt   = S_COPY;
            end
          end
          OP_DELETE, OP_LOOKUP: begin
            if (rec_used && (rec_len == key_count_r)) begin
              if (word_r.operation == OP_LOOKUP) begin
                found_nxt = rec_age;
              end
              state_nxt = S_CMP;
            end
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end

      // Copy the key buffer into the slot's name area, one character a cycle.
      S_COPY: begin
        nb_wr_en = pend_r;
        if (walk_end) begin
          pend_nxt  = 1'b0;
          state_nxt = S_DONE;
        end else begin
          key_rd_en    = 1'b1;
          pend_nxt     = 1'b1;
          wr_idx_nxt   = walk_idx_r;
          walk_idx_nxt = walk_idx_r + 1'b1;
        end
      end

      // Compare the stored name with the key, one character a cycle.
      S_CMP: begin
        if (pend_r && (key_rd_data != nb_rd_data)) begin
          status_nxt = STAT_NOT_FOUND;
          found_nxt  = '0;
          state_nxt  = S_DONE;
        end else if (walk_end) begin
          status_nxt = STAT_OK;
          if (word_r.operation == OP_DELETE) begin
            rec_wr_en = 1'b1;
          end
          state_nxt = S_DONE;
        end else begin
          key_rd_en    = 1'b1;
          nb_rd_en     = 1'b1;
          pend_nxt     = 1'b1;
          walk_idx_nxt = walk_idx_r + 1'b1;
        end
      end

      // Hand the result to the output register and restart the name collector.
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt           = 1'b1;
          out_word_nxt.status     = status_r;
          out_word_nxt.found_age  = found_r;
          out_word_nxt.slot_index = slot_ext[SLOT_OUT_W-1:0];
          key_count_nxt           = '0;
          hash_nxt                = '0;
          state_nxt               = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_idx_r   <= '0;
      key_count_r <= '0;
      hash_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      key_count_r <= key_count_nxt;
      hash_r      <= hash_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    word_r      <= word_nxt;
    walk_idx_r  <= walk_idx_nxt;
    wr_idx_r    <= wr_idx_nxt;
    name_base_r <= name_base_nxt;
    status_r    <= status_nxt;
    found_r     <= found_nxt;
    out_word_r  <= out_word_nxt;
  end

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for direct_mapped_name_table: streams names word by word,
// predicts every result from its own copy of the table and compares it field by field.
// Depends on dmnt_pkg and the direct_mapped_name_table RTL.
module tb;
  import dmnt_pkg::*;

  localparam int TABLE_SLOTS  = 100;
  localparam int NAME_MAX     = 32;
  localparam int LONGEST_NAME = 40;
  localparam int POOL         = 24;
  localparam int RANDOM_WORDS = 550;
  localparam int DRAIN_CYCLES = 200;

  // Operation code that the block has no meaning for; it must answer not found.
  localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_TOGGLE
  } stall_mode_t;

  // A queued word plus a flag that holds it back until every answer is in.
  typedef struct packed {
    logic     hold_back;
    in_word_t word;
  } pend_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_word_t  in_word   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;

  direct_mapped_name_table #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .NAME_MAX_LEN(NAME_MAX)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predicted table contents and the name being collected.
  logic             slot_taken [TABLE_SLOTS];
  logic [AGE_W-1:0] slot_age_q [TABLE_SLOTS];
  int               slot_len   [TABLE_SLOTS];
  logic [6:0]       slot_chars [TABLE_SLOTS][NAME_MAX];
  logic [6:0]       key_chars  [NAME_MAX];
  int               key_len    = 0;
  int               run_hash   = 0;
  bit               key_truncated = 0;

  out_word_t answer_q[$];
  pend_t     pend_q[$];

  int fail_count    = 0;
  int words_in      = 0;
  int answers_seen  = 0;
  int gen_words     = 0;
  int ops_seen[4]   = '{0, 0, 0, 0};
  int status_seen[4] = '{0, 0, 0, 0};
  int over_long     = 0;

  // Stimulus name pool; the extra entry holds one-off noise names.
  logic [6:0] pool_chars [POOL+1][LONGEST_NAME];
  int         pool_len   [POOL+1];

  task automatic log_fail(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endtask

  // Fold one accepted word into the predicted table; the last word of a name
  // yields one expected answer.
  task automatic table_apply(input in_word_t w);
    out_word_t res;
    int        slot;
    bit        same;
    if (key_len < NAME_MAX) begin
      run_hash = ((run_hash + w.key_char) * w.key_char) % TABLE_SLOTS;
      key_chars[key_len] = w.key_char;
      key_len++;
    end else begin
      key_truncated = 1;
    end
    if (w.key_last) begin
      slot = run_hash;
      same = slot_taken[slot] && (slot_len[slot] == key_len);
      for (int i = 0; i < key_len; i++) begin
        if (slot_chars[slot][i] != key_chars[i]) same = 0;
      end
      res.status     = STAT_NOT_FOUND;
      res.found_age  = '0;
      res.slot_index = 7'(slot);
      case (w.operation)
        OP_INSERT: begin
          if (slot_taken[slot]) begin
            res.status = STAT_OCCUPIED;
          end else begin
            slot_taken[slot] = 1'b1;
            slot_age_q[slot] = w.entry_age;
            slot_len[slot]   = key_len;
            for (int i = 0; i < key_len; i++) slot_chars[slot][i] = key_chars[i];
            res.status = STAT_OK;
          end
        end
        OP_DELETE: begin
          if (same) begin
            slot_taken[slot] = 1'b0;
            res.status = STAT_OK;
          end
        end
        OP_LOOKUP: begin
          if (same) begin
            res.status    = STAT_OK;
            res.found_age = slot_age_q[slot];
          end
        end
        default: ;
      endcase
      answer_q.push_back(res);
      ops_seen[w.operation]++;
      status_seen[res.status]++;
      if (key_truncated) over_long++;
      key_len       = 0;
      run_hash      = 0;
      key_truncated = 0;
    end
  endtask

  // Random name: mostly short, some medium, a few near, at or beyond the length limit.
  task automatic make_name(input int p);
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) pool_len[p] = $urandom_range(1, 5);
    else if (r < 88) pool_len[p] = $urandom_range(6, 20);
    else if (r < 94) pool_len[p] = $urandom_range(NAME_MAX - 2, NAME_MAX);
    else pool_len[p] = $urandom_range(NAME_MAX + 1, LONGEST_NAME);
    for (int i = 0; i < LONGEST_NAME; i++) pool_chars[p][i] = 7'($urandom_range(0, 127));
  endtask

  // Queue a pool name as words. Characters past the limit get fresh values each
  // time, so truncated names must still match.
  task automatic queue_name(input int p, input logic [OP_W-1:0] op,
                            input logic [AGE_W-1:0] age, input bit drain);
    pend_t e;
    for (int i = 0; i < pool_len[p]; i++) begin
      e.hold_back          = drain && (i == 0);
      e.word.key_last      = (i == pool_len[p] - 1);
      e.word.key_char      = (i < NAME_MAX) ? pool_chars[p][i] : 7'($urandom_range(0, 127));
      e.word.operation     = e.word.key_last ? op : OP_W'($urandom_range(0, 3));
      e.word.entry_age     = e.word.key_last ? age : AGE_W'($urandom);
      pend_q.push_back(e);
      gen_words++;
    end
  endtask

  function automatic logic [AGE_W-1:0] pick_age();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return AGE_W'($urandom);
  endfunction

  // Sender: bursts of words separated by random gaps; a held-back word waits
  // until the predicted answers are all in.
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk) begin
    pend_t head;
    if (!rst_n) begin
      in_valid   <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else if (!(in_valid && in_stall)) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pend_q.size() == 0 ||
                   (pend_q[0].hold_back && (in_valid || answer_q.size() != 0))) begin
        in_valid <= 1'b0;
      end else begin
        head = pend_q.pop_front();
        in_valid <= 1'b1;
        in_word  <= head.word;
        if (burst_left <= 1) begin
          burst_left <= ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 16);
          gap_left   <= $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // Receiver: stall behavior switches between random modes: none, light, heavy and toggling.
  stall_mode_t stall_mode = STALL_NONE;
  int          stall_span = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_span <= 0;
    end else begin
      if (stall_span == 0) begin
        stall_mode <= stall_mode_t'($urandom_range(0, 3));
        stall_span <= $urandom_range(20, 120);
      end else begin
        stall_span <= stall_span - 1;
      end
      case (stall_mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:     out_stall <= ~out_stall;
      endcase
    end
  end

  // Monitor: predicts on every accepted input word and checks every accepted answer.
  always @(posedge clk) begin
    out_word_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        table_apply(in_word);
        words_in++;
      end
      if (out_valid && !out_stall) begin
        answers_seen++;
        if (answer_q.size() == 0) begin
          log_fail($sformatf("unexpected answer: status %0d age %0h slot %0d",
                             out_word.status, out_word.found_age, out_word.slot_index));
        end else begin
          want = answer_q.pop_front();
          if (out_word.status !== want.status)
            log_fail($sformatf("answer %0d status: expected %0d, got %0d",
                               answers_seen, want.status, out_word.status));
          if (out_word.found_age !== want.found_age)
            log_fail($sformatf("answer %0d found_age: expected %0h, got %0h",
                               answers_seen, want.found_age, out_word.found_age));
          if (out_word.slot_index !== want.slot_index)
            log_fail($sformatf("answer %0d slot_index: expected %0d, got %0d",
                               answers_seen, want.slot_index, out_word.slot_index));
        end
      end
    end
  end

  // Main sequence: build the stimulus, release reset, wait for the drain, report.
  initial begin
    int r;
    int p;
    int names;
    for (int s = 0; s < TABLE_SLOTS; s++) slot_taken[s] = 1'b0;

    // Directed names: a plain letter, the extreme characters, and two
    // single-character names that both hash to slot zero.
    pool_len[0] = 1;  pool_chars[0][0] = 7'h41;
    pool_len[1] = 2;  pool_chars[1][0] = 7'h00;  pool_chars[1][1] = 7'h7f;
    pool_len[2] = 1;  pool_chars[2][0] = 7'd10;
    pool_len[3] = 1;  pool_chars[3][0] = 7'd20;

    queue_name(0, OP_LOOKUP,   16'h1234, 0);  // empty table
    queue_name(0, OP_INSERT,   16'hffff, 0);
    queue_name(0, OP_INSERT,   16'h0001, 0);  // slot already taken
    queue_name(0, OP_LOOKUP,   16'h0000, 0);
    queue_name(0, OP_RESERVED, 16'h5555, 0);  // reserved code leaves the table alone
    queue_name(0, OP_DELETE,   16'haaaa, 0);
    queue_name(0, OP_LOOKUP,   16'h0000, 0);
    queue_name(1, OP_INSERT,   16'h0000, 0);
    queue_name(1, OP_LOOKUP,   16'hffff, 0);
    queue_name(2, OP_INSERT,   16'h8001, 0);
    queue_name(3, OP_DELETE,   16'h0000, 0);  // same slot, other name
    queue_name(3, OP_LOOKUP,   16'h0000, 0);
    queue_name(3, OP_INSERT,   16'h7ffe, 0);
    queue_name(2, OP_DELETE,   16'h0000, 0);

    // Random part: operations on a small pool of names so that inserts meet
    // lookups and deletes of the same names, with some noise names mixed in.
    for (int i = 0; i < POOL; i++) make_name(i);
    names = 0;
    while (gen_words < RANDOM_WORDS + 16) begin
      r = $urandom_range(0, 99);
      p = $urandom_range(0, POOL - 1);
      if (r < 40) begin
        queue_name(p, OP_INSERT, pick_age(), names % 60 == 0);
      end else if (r < 65) begin
        queue_name(p, OP_LOOKUP, pick_age(), names % 60 == 0);
      end else if (r < 88) begin
        queue_name(p, OP_DELETE, pick_age(), names % 60 == 0);
      end else if (r < 93) begin
        queue_name(p, OP_RESERVED, pick_age(), names % 60 == 0);
      end else begin
        make_name(POOL);
        queue_name(POOL, OP_W'($urandom_range(0, 3)), pick_age(), names % 60 == 0);
      end
      if ($urandom_range(0, 9) == 0) make_name($urandom_range(0, POOL - 1));
      names++;
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (pend_q.size() != 0 || in_valid) @(posedge clk);
    while (answer_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d words and %0d answers: %0d insert, %0d delete, %0d lookup, %0d reserved.",
             words_in, answers_seen, ops_seen[OP_INSERT], ops_seen[OP_DELETE],
             ops_seen[OP_LOOKUP], ops_seen[OP_RESERVED]);
    $display("Answers: %0d ok, %0d occupied, %0d not found; %0d over-long names; %0d failures.",
             status_seen[STAT_OK], status_seen[STAT_OCCUPIED], status_seen[STAT_NOT_FOUND],
             over_long, fail_count);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run, including the clearing pass.
  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

>>> files.f
sv/dmnt_pkg.sv
sv/dmnt_ram.sv
sv/dmnt_hash.sv
sv/direct_mapped_name_table.sv
test/tb.sv
